// ----- src/csfw_pkg.sv -----
package csfw_pkg;

	localparam int MAX_WAITERS = 16;
	localparam int ID_WIDTH    = 8;
	localparam int IDX_W       = $clog2(MAX_WAITERS);
	localparam int TOTAL_W     = $clog2(MAX_WAITERS + 1);
	localparam int COUNT_W     = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_FULL = TOTAL_W'(MAX_WAITERS);

	typedef enum logic [1:0] {
		MODE_DOWN   = 2'd0,
		MODE_TRY    = 2'd1,
		MODE_CANCEL = 2'd2,
		MODE_UP     = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_GRANTED     = 4'd0,
		ST_QUEUED      = 4'd1,
		ST_WOULD_BLOCK = 4'd2,
		ST_INVALID     = 4'd3,
		ST_CANCELLED   = 4'd4,
		ST_NOT_FOUND   = 4'd5,
		ST_COUNTED_UP  = 4'd6,
		ST_WOKEN       = 4'd7,
		ST_FULL        = 4'd8
	} status_t;

	typedef struct packed {
		mode_t             mode;
		logic [7:0]        waiter_id;
		logic              timeout_negative;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [7:0]        woken_id;
		logic [COUNT_W-1:0] count_now;
		logic [4:0]        waiters_now;
	} out_item_t;

	typedef enum logic {
		CTL_IDLE = 1'b0,
		CTL_EXEC = 1'b1
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

endpackage

// ----- src/csfw_ctrl.sv -----
module csfw_ctrl
	import csfw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_cmd_t cmd
);

	ctl_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		in_stall    = 1'b1;
		unique case (state_q)
			CTL_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				// The item waits here only while the previous result is still held.
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = CTL_IDLE;
				end
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/csfw_dp.sv -----
module csfw_dp
	import csfw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  in_item_t           in_item,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	output out_item_t          out_item
);

	in_item_t            item_q;
	out_item_t           out_q;
	logic [COUNT_W-1:0]  count_q, count_d;
	logic [TOTAL_W-1:0]  total_q, total_d;
	logic [ID_WIDTH-1:0] queue_q [MAX_WAITERS];
	logic [ID_WIDTH-1:0] queue_d [MAX_WAITERS];

	logic [ID_WIDTH-1:0]    id;
	logic [MAX_WAITERS-1:0] match, first, shift_mask;
	status_t                status;
	logic [ID_WIDTH-1:0]    woken;

	assign id = item_q.waiter_id[ID_WIDTH-1:0];

	// Every queue cell compares against the identifier; the lowest hit is the oldest.
	always_comb begin
		for (int i = 0; i < MAX_WAITERS; i++) begin
			match[i] = (queue_q[i] == id) && (TOTAL_W'(i) < total_q);
		end
		first = match & (~match + MAX_WAITERS'(1));
	end

	always_comb begin
		count_d    = count_q;
		total_d    = total_q;
		status     = ST_GRANTED;
		woken      = '0;
		shift_mask = '0;
		for (int i = 0; i < MAX_WAITERS; i++) begin
			queue_d[i] = queue_q[i];
		end
		case (item_q.mode)
			MODE_DOWN: begin
				if (count_q != '0) begin
					count_d = count_q - COUNT_W'(1);
				end else if (item_q.timeout_negative) begin
					status = ST_INVALID;
				end else if (total_q == TOTAL_FULL) begin
					status = ST_FULL;
				end else begin
					for (int i = 0; i < MAX_WAITERS; i++) begin
						if (TOTAL_W'(i) == total_q) begin
							queue_d[i] = id;
						end
					end
					total_d = total_q + TOTAL_W'(1);
					status  = ST_QUEUED;
				end
			end
			MODE_TRY: begin
				if (count_q != '0) begin
					count_d = count_q - COUNT_W'(1);
				end else begin
					status = ST_WOULD_BLOCK;
				end
			end
			MODE_CANCEL: begin
				if (match != '0) begin
					// Cells from the hit upwards take their upper neighbour.
					shift_mask = ~(first - MAX_WAITERS'(1));
					total_d    = total_q - TOTAL_W'(1);
					status     = ST_CANCELLED;
				end else begin
					status = ST_NOT_FOUND;
				end
			end
			default: begin
				if (total_q != '0) begin
					woken      = queue_q[0];
					shift_mask = '1;
					total_d    = total_q - TOTAL_W'(1);
					status     = ST_WOKEN;
				end else begin
					if (count_q != COUNT_MAX) begin
						count_d = count_q + COUNT_W'(1);
					end
					status = ST_COUNTED_UP;
				end
			end
		endcase
		for (int i = 0; i < MAX_WAITERS - 1; i++) begin
			if (shift_mask[i]) begin
				queue_d[i] = queue_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (cfg_we) begin
			if (total_q == '0) begin
				count_q <= cfg_wdata;
			end
		end else if (cmd.commit) begin
			count_q <= count_d;
			total_q <= total_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
		if (cmd.commit) begin
			for (int i = 0; i < MAX_WAITERS; i++) begin
				queue_q[i] <= queue_d[i];
			end
			out_q.status      <= status;
			out_q.woken_id    <= 8'(woken);
			out_q.count_now   <= count_d;
			out_q.waiters_now <= 5'(total_d);
		end
	end

	assign out_item = out_q;

endmodule

// ----- src/counting_semaphore_fifo_waiters_top.sv -----
// An accepted item is first captured, then its update is committed and the result registered;
// no new item is taken until that update is committed, as the controller alternates its capture
// and update steps; the update of the waiter cells is held while a result waits.
// Reset (arst_n low) clears the count and the waiter total to zero;
// the contents of the waiter cells are left unset.
module counting_semaphore_fifo_waiters_top
	import csfw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_item,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	dp_cmd_t cmd;

	csfw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	csfw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_item  (out_item)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while the previous one is still in work");

	a_count_or_waiters: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.count_now == '0) || (out_item.waiters_now == '0))
		else $error("positive count reported with waiters queued");

	a_waiters_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.waiters_now <= 5'(MAX_WAITERS))
		else $error("waiter total beyond queue depth");

	a_woken_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status != ST_WOKEN) |-> out_item.woken_id == '0)
		else $error("woken identifier set without a wake-up");

endmodule

// ----- bench/testbench.sv -----
module testbench;
	import csfw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		in_item_t    item;
		int unsigned gap;
	} stim_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_item_t           in_item = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_item;
	logic               cfg_we = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;

	// Predicted semaphore state.
	logic [COUNT_W-1:0]  sem_count = '0;
	logic [ID_WIDTH-1:0] wait_ids [MAX_WAITERS];
	int                  wait_total = 0;

	stim_t       stim_q[$];
	out_item_t   pending_results[$];
	out_item_t   want_res;
	int unsigned idle_cnt = 0;
	int unsigned stall_left = 0;
	bit          no_idle = 1'b0;
	int          mismatches = 0;

	counting_semaphore_fifo_waiters_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (mismatches < 50)
			$display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Removes one waiter and closes the gap so that the order is kept.
	function automatic void drop_waiter(int pos);
		for (int i = pos; i + 1 < wait_total; i++)
			wait_ids[i] = wait_ids[i + 1];
		wait_total--;
	endfunction

	function automatic out_item_t semaphore_predict(in_item_t it);
		out_item_t r;
		int        hit;
		r = '0;
		hit = -1;
		case (it.mode)
			MODE_DOWN: begin
				if (sem_count != 0) begin
					sem_count--;
					r.status = ST_GRANTED;
				end else if (it.timeout_negative) begin
					r.status = ST_INVALID;
				end else if (wait_total >= MAX_WAITERS) begin
					r.status = ST_FULL;
				end else begin
					wait_ids[wait_total] = it.waiter_id;
					wait_total++;
					r.status = ST_QUEUED;
				end
			end
			MODE_TRY: begin
				if (sem_count != 0) begin
					sem_count--;
					r.status = ST_GRANTED;
				end else begin
					r.status = ST_WOULD_BLOCK;
				end
			end
			MODE_CANCEL: begin
				for (int i = 0; i < wait_total; i++)
					if (hit < 0 && wait_ids[i] == it.waiter_id)
						hit = i;
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					drop_waiter(hit);
					r.status = ST_CANCELLED;
				end
			end
			default: begin
				if (wait_total > 0) begin
					r.woken_id = wait_ids[0];
					drop_waiter(0);
					r.status = ST_WOKEN;
				end else begin
					if (sem_count != COUNT_MAX)
						sem_count++;
					r.status = ST_COUNTED_UP;
				end
			end
		endcase
		r.count_now = sem_count;
		r.waiters_now = 5'(wait_total);
		return r;
	endfunction

	// Driver: each item waits out its own idle gap before it is offered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			idle_cnt <= 0;
		end else begin
			if (in_valid && !in_stall)
				pending_results.push_back(semaphore_predict(in_item));
			if (!in_valid || !in_stall) begin
				if (stim_q.size() != 0 && idle_cnt >= stim_q[0].gap) begin
					in_item <= stim_q[0].item;
					in_valid <= 1'b1;
					idle_cnt <= 0;
					void'(stim_q.pop_front());
				end else begin
					in_valid <= 1'b0;
					if (stim_q.size() != 0)
						idle_cnt <= idle_cnt + 1;
				end
			end
		end
	end

	// Monitor: checks each result and, unless no_idle is set, holds off the next one for a random time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending, status", out_item.status, 0);
				end else begin
					want_res = pending_results.pop_front();
					if (out_item.status != want_res.status)
						report_mismatch("status", out_item.status, want_res.status);
					if (out_item.woken_id != want_res.woken_id)
						report_mismatch("woken_id", out_item.woken_id, want_res.woken_id);
					if (out_item.count_now != want_res.count_now)
						report_mismatch("count_now", out_item.count_now, want_res.count_now);
					if (out_item.waiters_now != want_res.waiters_now)
						report_mismatch("waiters_now", out_item.waiters_now,
							want_res.waiters_now);
				end
				stall_left <= no_idle ? 0 : $urandom_range(0, 8);
				out_stall <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic queue_item(mode_t m, logic [7:0] id, logic neg);
		stim_t s;
		s.item.mode = m;
		s.item.waiter_id = id;
		s.item.timeout_negative = neg;
		s.gap = no_idle ? 0 : $urandom_range(0, 8);
		stim_q.push_back(s);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (stim_q.size() != 0 || in_valid || pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// The count is only loaded while no waiter is queued.
	task automatic write_initial_count(logic [COUNT_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (wait_total == 0)
			sem_count = v;
	endtask

	// kind 0 is a balanced mix, kind 1 fills the queue, kind 2 is mostly up items.
	task automatic run_mix(int kind, int n, logic [COUNT_W-1:0] start, bit quiet);
		logic [7:0] pool [6];
		int         lim_down;
		int         lim_try;
		int         lim_cancel;
		int         pick;
		logic [7:0] id;
		mode_t      m;
		case (kind)
			1: begin
				lim_down = 55; lim_try = 65; lim_cancel = 80;
			end
			2: begin
				lim_down = 20; lim_try = 35; lim_cancel = 50;
			end
			default: begin
				lim_down = 35; lim_try = 50; lim_cancel = 70;
			end
		endcase
		write_initial_count(start);
		foreach (pool[i])
			pool[i] = 8'($urandom_range(0, 255));
		@(negedge clk);
		no_idle = quiet;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < lim_down)
				m = MODE_DOWN;
			else if (pick < lim_try)
				m = MODE_TRY;
			else if (pick < lim_cancel)
				m = MODE_CANCEL;
			else
				m = MODE_UP;
			// A small pool of identifiers makes duplicates and cancel hits common.
			if ($urandom_range(0, 4) != 0)
				id = pool[$urandom_range(0, 5)];
			else
				id = 8'($urandom_range(0, 255));
			queue_item(m, id, $urandom_range(0, 6) == 0);
		end
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty semaphore: blocking, rejection, queueing, cancel and wake-up order.
		queue_item(MODE_TRY, 8'h00, 1'b1);
		queue_item(MODE_DOWN, 8'hFF, 1'b1);
		queue_item(MODE_DOWN, 8'hA5, 1'b0);
		queue_item(MODE_DOWN, 8'h5A, 1'b0);
		queue_item(MODE_DOWN, 8'hA5, 1'b0);
		queue_item(MODE_DOWN, 8'hFF, 1'b0);
		queue_item(MODE_CANCEL, 8'hA5, 1'b0);
		queue_item(MODE_CANCEL, 8'h33, 1'b0);
		queue_item(MODE_UP, 8'h00, 1'b0);
		queue_item(MODE_UP, 8'h00, 1'b0);
		queue_item(MODE_UP, 8'h00, 1'b0);
		queue_item(MODE_UP, 8'h00, 1'b0);
		queue_item(MODE_UP, 8'h00, 1'b0);
		queue_item(MODE_TRY, 8'h01, 1'b0);
		queue_item(MODE_DOWN, 8'h02, 1'b1);
		queue_item(MODE_TRY, 8'h03, 1'b0);
		queue_item(MODE_CANCEL, 8'h11, 1'b0);
		queue_item(MODE_DOWN, 8'h11, 1'b0);
		wait_drained();

		// A waiter is still queued, so the count must not be loaded.
		write_initial_count(16'hFFFF);
		@(negedge clk);
		queue_item(MODE_UP, 8'h00, 1'b0);
		queue_item(MODE_UP, 8'h00, 1'b0);
		wait_drained();

		// Saturation at the top of the count.
		write_initial_count(16'hFFFF);
		@(negedge clk);
		queue_item(MODE_UP, 8'hFF, 1'b1);
		queue_item(MODE_TRY, 8'h00, 1'b0);
		wait_drained();

		run_mix(0, 175, 16'd1, 1'b0);
		run_mix(2, 175, 16'hFFFF, 1'b0);
		run_mix(1, 175, 16'd0, 1'b0);
		run_mix(2, 175, 16'd2, 1'b1);
		run_mix(0, 175, 16'($urandom_range(0, 65535)), 1'b0);
		run_mix(1, 175, 16'd0, 1'b0);
		run_mix(2, 175, 16'($urandom_range(0, 20)), 1'b0);
		run_mix(0, 175, 16'hFFFF, 1'b1);
		run_mix(1, 175, 16'd0, 1'b0);
		run_mix(0, 175, 16'($urandom_range(0, 65535)), 1'b0);

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("counting_semaphore_fifo_waiters_top: match");
		else
			$display("counting_semaphore_fifo_waiters_top: mismatch");
		$finish;
	end

	initial begin
		#5ms;
		$display("counting_semaphore_fifo_waiters_top: mismatch");
		$finish;
	end

endmodule
